// ===== rtl/kpt_pkg.sv =====
// shared types and constants of the keyed parameter table
package kpt_pkg;

    localparam int DEFAULT_ENTRIES = 32;
    localparam logic [7:0] RESERVED_KEY = 8'hFF;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_HIT      = 3'd0,
        STATUS_INSERTED = 3'd1,
        STATUS_MISS     = 3'd2,
        STATUS_FULL     = 3'd3,
        STATUS_RESERVED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [7:0] read_value;
        status_t    status;
    } result_t;

endpackage

// ===== rtl/kpt_mem.sv =====
// entry memory: one write port, one read port with registered read data
module kpt_mem #(
    parameter int ENTRIES = 32,
    parameter int AW      = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [ENTRIES];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/kpt_ctrl.sv =====
// operation sequencer: linear scan of the entry memory for lookups and updates, then write back on an update
module kpt_ctrl #(
    parameter int ENTRIES = 32,
    parameter int AW      = 5,
    parameter int CW      = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_kind,
    input  logic [7:0]        in_key,
    input  logic [7:0]        in_value,
    output logic              done,
    output kpt_pkg::result_t  result,
    input  logic              out_free,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [15:0]       wr_data,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [15:0]       rd_data
);
    import kpt_pkg::*;

    state_t        state_reg, state_next;
    kind_t         kind_reg, kind_next;
    logic [7:0]    key_reg, key_next;
    logic [7:0]    value_reg, value_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    result_t       result_reg, result_next;
    logic          hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    // key sits in the upper byte of each memory word
    assign hit = pend_valid_reg && (rd_data[15:8] == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        result_next     = result_reg;
        in_ready        = 1'b0;
        done            = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = {key_reg, value_reg};
        rd_en           = 1'b0;
        rd_addr         = issue_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next       = kind_t'(in_kind);
                    key_next        = in_key;
                    value_next      = in_value;
                    issue_next      = '0;
                    pend_valid_next = 1'b0;
                    result_next     = '{read_value: 8'd0, status: STATUS_MISS};
                    state_next      = ST_DONE;
                    case (in_kind)
                        KIND_LOOKUP:
                        begin
                            if (in_key != RESERVED_KEY)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            if (in_key == RESERVED_KEY)
                            begin
                                result_next.status = STATUS_RESERVED;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next         = '0;
                            result_next.status = STATUS_HIT;
                        end
                        default:
                        begin
                            result_next.status = STATUS_MISS;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        result_next = '{read_value: rd_data[7:0], status: STATUS_HIT};
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = pend_idx_reg;
                        result_next = '{read_value: 8'd0, status: STATUS_HIT};
                    end
                end
                else if (issue_reg < count_reg)
                begin
                    rd_en           = 1'b1;
                    issue_next      = issue_reg + CW'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[AW-1:0];
                end
                else
                begin
                    // last compare done without a match
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        result_next = '{read_value: 8'd0, status: STATUS_MISS};
                    end
                    else if (count_reg == CW'(ENTRIES))
                    begin
                        result_next = '{read_value: 8'd0, status: STATUS_FULL};
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[AW-1:0];
                        count_next  = count_reg + CW'(1);
                        result_next = '{read_value: 8'd0, status: STATUS_INSERTED};
                    end
                end
            end

            ST_DONE:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result = result_reg;

endmodule

// ===== rtl/keyed_parameter_table.sv =====
// top level of the keyed parameter table: sequencer, entry memory, output register
//
//  channel  | dir | tdata                      | tuser        | meaning
//  ---------+-----+----------------------------+--------------+-------------------------
//  s_*      | in  | [7:0] key, [15:8] value    | [1:0] kind   | lookup / update / clear
//  m_*      | out | [7:0] read_value           | [2:0] status | one result per transfer
//
// a lookup or update scans the entries in insertion order, one memory read per cycle;
// clear, the unused kind and the reserved key skip the scan and go straight to the result
// the scan reads one entry at a time through the single read port of the entry memory
// reset clears the entry count but not the memory: memory contents past the count are never read
// a result waits in the output register while m_tready is low; the next input
// transfer is taken once the result has been loaded there
module keyed_parameter_table #(
    parameter int ENTRIES = kpt_pkg::DEFAULT_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key, [15:8] value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] read_value
    output logic [2:0]  m_tuser    // [2:0] status
);
    import kpt_pkg::*;

    // address width for the memory, count width holds 0..ENTRIES
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic          done;
    result_t       result;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    logic          out_valid_reg, out_valid_next;
    result_t       out_result_reg, out_result_next;

    // output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    kpt_ctrl #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_key   (s_tdata[7:0]),
        .in_value (s_tdata[15:8]),
        .done     (done),
        .result   (result),
        .out_free (out_free),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    kpt_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: loads a finished result, holds it until the transfer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (done && out_free)
        begin
            out_valid_next  = 1'b1;
            out_result_next = result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.read_value;
    assign m_tuser  = out_result_reg.status;

endmodule
